// ===== src/snsf_pkg.sv =====
// Shared constants and codes for the surface normal spring force block.
`timescale 1ns / 1ps
`default_nettype none
package snsf_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MAX_CONTRIB_DEF = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [31:0] SPRING_K_RST    = 32'h0001_0000;
  localparam logic [31:0] REST_LENGTH_RST = 32'h0001_0000;
  localparam logic [63:0] CUTOFF_SQ_RST   = 64'h0000_0001_0000_0000;
  localparam logic [31:0] TANG_CUTOFF_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING_K    = 2'd0,
    REG_REST_LENGTH = 2'd1,
    REG_CUTOFF_SQ   = 2'd2,
    REG_TANG_CUTOFF = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_APPLIED    = 2'd0,
    ST_SKIPPED    = 2'd1,
    ST_NO_SURFACE = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ===== src/surface_normal_spring_force.sv =====
// Surface normal spring force: a fully pipelined pair force evaluator.
//
// Input words arrive on in_valid/in_ready, result words leave on out_valid/out_ready.
// Configuration (spring_k, rest_length, cutoff_sq, tangential_cutoff) is written
// through cfg_we/cfg_index/cfg_data, one register per cycle. The user must write it
// only while the block is idle; the block itself does not enforce this.
//
// The pipeline is 46 register stages deep. One word is accepted every cycle while
// in_ready is high. The depth is set by the bit-serial units: the 32-step square root
// of |n|^2 (8 stages), the 64-step normal distance divide (16 stages) and the 64-step
// divide by the contributor count (8 stages), plus the multiply stages around them.
//
// When the receiver stalls, the word in the last stage moves into a skid register and
// the pipeline advances once more; in_ready then drops until the skid word is taken.
// Synchronous active-low reset clears all valid bits and loads the register defaults
// (spring_k, rest_length and tangential_cutoff 1.0, cutoff_sq 1.0).
`timescale 1ns / 1ps
`default_nettype none
module surface_normal_spring_force #(
  parameter int COORD_WIDTH      = snsf_pkg::COORD_WIDTH_DEF,
  parameter int MAX_CONTRIBUTORS = snsf_pkg::MAX_CONTRIB_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]      in_del_x,
  input  wire logic signed [COORD_WIDTH-1:0]      in_del_y,
  input  wire logic signed [COORD_WIDTH-1:0]      in_del_z,
  input  wire logic signed [15:0]                 in_normal_x,
  input  wire logic signed [15:0]                 in_normal_y,
  input  wire logic signed [15:0]                 in_normal_z,
  input  wire logic [6:0]                         in_contributors,
  input  wire logic [16:0]                        in_special_scale,
  input  wire logic [1:0]                         in_surface_role,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [31:0]                      out_force_x,
  output logic signed [31:0]                      out_force_y,
  output logic signed [31:0]                      out_force_z,
  output logic [47:0]                             out_pair_energy,
  output logic [1:0]                              out_status,
  input  wire logic                               cfg_we,
  input  wire logic [snsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [snsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int PDW  = CW + 16;
  localparam int SQW  = (2 * CW > 64) ? 2 * CW + 1 : 65;
  localparam int CNTW = $clog2(MAX_CONTRIBUTORS + 1);
  localparam int CMPW = (CNTW > 7) ? CNTW : 7;

  // stage map
  localparam int S_MAG     = 0;
  localparam int S_PROD    = 1;
  localparam int S_SUM     = 2;
  localparam int S_DOT     = 3;
  localparam int ISQ_ST    = 8;
  localparam int ISQ_STEPS = 32 / ISQ_ST;
  localparam int ISQ_LAST  = S_DOT + ISQ_ST;
  localparam int DIV_ST    = 16;
  localparam int DIV_STEPS = 64 / DIV_ST;
  localparam int DIV_FIRST = ISQ_LAST + 1;
  localparam int DIV_LAST  = DIV_FIRST + DIV_ST - 1;
  localparam int S_T1      = DIV_LAST + 1;
  localparam int S_T2      = S_T1 + 1;
  localparam int S_F1      = S_T2 + 1;
  localparam int S_F2      = S_F1 + 1;
  localparam int S_F3      = S_F2 + 1;
  localparam int S_F4      = S_F3 + 1;
  localparam int S_F5      = S_F4 + 1;
  localparam int S_F6      = S_F5 + 1;
  localparam int CDV_ST    = 8;
  localparam int CDV_STEPS = 64 / CDV_ST;
  localparam int CDV_LAST  = S_F6 + CDV_ST;
  localparam int S_G1      = CDV_LAST + 1;
  localparam int S_G2      = S_G1 + 1;
  localparam int NST       = S_G2 + 1;

  typedef struct packed {
    logic [2:0][CW-1:0] dm;
    logic [2:0][15:0]   nm;
    logic [2:0]         nn;
    logic [2:0]         pn;
    logic [CNTW-1:0]    cnt;
    logic [16:0]        scale;
    logic [1:0]         role;
  } s1_t;

  typedef struct packed {
    logic [2:0][63:0]   sq;
    logic [2:0][PDW-1:0] pd;
    logic [2:0][31:0]   ns;
    logic [2:0][15:0]   nm;
    logic [2:0]         nn;
    logic [2:0]         pn;
    logic [CNTW-1:0]    cnt;
    logic [16:0]        scale;
    logic [1:0]         role;
  } s2_t;

  typedef struct packed {
    logic [63:0]        rsq;
    logic [31:0]        nsq;
    logic [63:0]        pos;
    logic [63:0]        neg;
    logic [2:0][15:0]   nm;
    logic [2:0]         nn;
    logic [CNTW-1:0]    cnt;
    logic [16:0]        scale;
    logic [1:0]         role;
  } s3_t;

  typedef struct packed {
    logic [63:0]        rsq;
    logic [63:0]        dot;
    logic [49:0]        dmag;
    logic               dneg;
    logic [47:0]        energy;
    logic [2:0][15:0]   nm;
    logic [2:0]         nn;
    logic [CNTW-1:0]    cnt;
    logic [16:0]        scale;
    logic               role0;
    snsf_pkg::status_t  st;
  } ctx_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } isq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] dq;
    logic [31:0] nr;
  } div_t;

  typedef struct packed {
    logic [CNTW-1:0] rem;
    logic [63:0]     dq;
  } cdv_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [49:0] lh;
    logic [63:0] hl;
    logic [49:0] hh;
  } ep_t;

  typedef struct packed {
    logic [2:0][47:0] fl;
    logic [2:0][47:0] fh;
  } fp_t;

  typedef struct packed {
    logic [2:0][31:0]  f;
    logic [47:0]       energy;
    snsf_pkg::status_t st;
  } res_t;

  function automatic isq_t isq_step(isq_t s);
    isq_t        o;
    logic [35:0] rn;
    logic [35:0] tr;
    o      = s;
    rn     = {s.rem[33:0], s.rad[63:62]};
    tr     = {2'b00, s.root, 2'b01};
    o.rad  = {s.rad[61:0], 2'b00};
    if (rn >= tr) begin
      o.rem  = rn - tr;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rn;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t s);
    div_t        o;
    logic [32:0] rs;
    logic [32:0] df;
    o  = s;
    rs = {s.rem, s.dq[63]};
    df = rs - {1'b0, s.nr};
    if (rs >= {1'b0, s.nr}) begin
      o.rem = df[31:0];
      o.dq  = {s.dq[62:0], 1'b1};
    end else begin
      o.rem = rs[31:0];
      o.dq  = {s.dq[62:0], 1'b0};
    end
    return o;
  endfunction

  function automatic cdv_t cdv_step(cdv_t s, logic [CNTW-1:0] d);
    cdv_t          o;
    logic [CNTW:0] rs;
    logic [CNTW:0] df;
    o  = s;
    rs = {s.rem, s.dq[63]};
    df = rs - {1'b0, d};
    if (rs >= {1'b0, d}) begin
      o.rem = df[CNTW-1:0];
      o.dq  = {s.dq[62:0], 1'b1};
    end else begin
      o.rem = rs[CNTW-1:0];
      o.dq  = {s.dq[62:0], 1'b0};
    end
    return o;
  endfunction

  // configuration registers
  logic [31:0] spring_k_r;
  logic [31:0] rest_length_r;
  logic [63:0] cutoff_sq_r;
  logic [31:0] tang_cutoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_k_r    <= snsf_pkg::SPRING_K_RST;
      rest_length_r <= snsf_pkg::REST_LENGTH_RST;
      cutoff_sq_r   <= snsf_pkg::CUTOFF_SQ_RST;
      tang_cutoff_r <= snsf_pkg::TANG_CUTOFF_RST;
    end else if (cfg_we) begin
      unique case (snsf_pkg::cfg_reg_t'(cfg_index))
        snsf_pkg::REG_SPRING_K:    spring_k_r    <= cfg_data[31:0];
        snsf_pkg::REG_REST_LENGTH: rest_length_r <= cfg_data[31:0];
        snsf_pkg::REG_CUTOFF_SQ:   cutoff_sq_r   <= cfg_data;
        snsf_pkg::REG_TANG_CUTOFF: tang_cutoff_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic [NST-1:0] v_r;
  logic           skid_v_r;
  logic           skid_v_nxt;
  logic           en;

  s1_t  s1_r,  s1_nxt;
  s2_t  s2_r,  s2_nxt;
  s3_t  s3_r,  s3_nxt;
  ctx_t ctx_r   [S_DOT:S_G1];
  ctx_t ctx_nxt [S_DOT:S_G1];
  isq_t isq_r   [S_DOT:ISQ_LAST];
  isq_t isq_nxt [S_DOT:ISQ_LAST];
  div_t div_r   [DIV_FIRST:DIV_LAST];
  div_t div_nxt [DIV_FIRST:DIV_LAST];
  cdv_t cdv_r   [S_F6:CDV_LAST];
  cdv_t cdv_nxt [S_F6:CDV_LAST];
  logic [63:0] nd2_r, nd2_nxt;
  logic [63:0] tc2_r, tc2_nxt;
  logic [50:0] t_r, t_nxt;
  logic [63:0] pl_r, pl_nxt;
  logic [50:0] ph_r, ph_nxt;
  logic [63:0] pre_r, pre_nxt;
  logic [63:0] pre2_r, pre2_nxt;
  ep_t  ep_r, ep_nxt;
  fp_t  fp_r, fp_nxt;
  res_t res_r, res_nxt;
  res_t skid_r;
  res_t out_sel;

  logic [2:0][CW-1:0] del_in;
  logic [2:0][15:0]   nrm_in;

  assign del_in = {in_del_z, in_del_y, in_del_x};
  assign nrm_in = {in_normal_z, in_normal_y, in_normal_x};

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_comb begin
    logic [CMPW-1:0]   cext;
    logic [2*CW-1:0]   sqp;
    logic [SQW-1:0]    sqe;
    logic [65:0]       sum66;
    logic [33:0]       nsum;
    logic [63:0]       pe;
    isq_t              is;
    div_t              ds;
    cdv_t              cs;
    logic [63:0]       tang2;
    logic [49:0]       proj;
    logic [66:0]       tp;
    logic [83:0]       full84;
    logic [113:0]      sum114;
    logic [79:0]       p80;
    logic [31:0]       mag32;
    logic              neg;
    logic              big;

    // S_MAG: split into sign and magnitude, clamp the contributor count
    for (int c = 0; c < 3; c++) begin
      s1_nxt.dm[c] = del_in[c][CW-1] ? (~del_in[c] + 1'b1) : del_in[c];
      s1_nxt.nn[c] = nrm_in[c][15];
      s1_nxt.nm[c] = nrm_in[c][15] ? (~nrm_in[c] + 1'b1) : nrm_in[c];
      s1_nxt.pn[c] = del_in[c][CW-1] ^ nrm_in[c][15];
    end
    cext = CMPW'(in_contributors);
    s1_nxt.cnt   = (cext > CMPW'(MAX_CONTRIBUTORS)) ? CNTW'(MAX_CONTRIBUTORS) : CNTW'(cext);
    s1_nxt.scale = in_special_scale;
    s1_nxt.role  = in_surface_role;

    // S_PROD: squares and projections
    for (int c = 0; c < 3; c++) begin
      sqp = s1_r.dm[c] * s1_r.dm[c];
      sqe = SQW'(sqp);
      s2_nxt.sq[c] = (|sqe[SQW-1:64]) ? '1 : sqe[63:0];
      s2_nxt.pd[c] = s1_r.dm[c] * s1_r.nm[c];
      s2_nxt.ns[c] = s1_r.nm[c] * s1_r.nm[c];
    end
    s2_nxt.nm    = s1_r.nm;
    s2_nxt.nn    = s1_r.nn;
    s2_nxt.pn    = s1_r.pn;
    s2_nxt.cnt   = s1_r.cnt;
    s2_nxt.scale = s1_r.scale;
    s2_nxt.role  = s1_r.role;

    // S_SUM
    sum66 = 66'(s2_r.sq[0]) + 66'(s2_r.sq[1]) + 66'(s2_r.sq[2]);
    s3_nxt.rsq = (|sum66[65:64]) ? '1 : sum66[63:0];
    nsum = 34'(s2_r.ns[0]) + 34'(s2_r.ns[1]) + 34'(s2_r.ns[2]);
    s3_nxt.nsq = nsum[31:0];
    s3_nxt.pos = '0;
    s3_nxt.neg = '0;
    for (int c = 0; c < 3; c++) begin
      pe = 64'(s2_r.pd[c]);
      if (s2_r.pn[c]) s3_nxt.neg = s3_nxt.neg + pe;
      else            s3_nxt.pos = s3_nxt.pos + pe;
    end
    s3_nxt.nm    = s2_r.nm;
    s3_nxt.nn    = s2_r.nn;
    s3_nxt.cnt   = s2_r.cnt;
    s3_nxt.scale = s2_r.scale;
    s3_nxt.role  = s2_r.role;

    // S_DOT: |d.n|, early skip tests, square root seed
    ctx_nxt[S_DOT].rsq    = s3_r.rsq;
    ctx_nxt[S_DOT].dot    = (s3_r.pos >= s3_r.neg) ? s3_r.pos - s3_r.neg
                                                   : s3_r.neg - s3_r.pos;
    ctx_nxt[S_DOT].dmag   = '0;
    ctx_nxt[S_DOT].dneg   = 1'b0;
    ctx_nxt[S_DOT].energy = '0;
    ctx_nxt[S_DOT].nm     = s3_r.nm;
    ctx_nxt[S_DOT].nn     = s3_r.nn;
    ctx_nxt[S_DOT].cnt    = s3_r.cnt;
    ctx_nxt[S_DOT].scale  = s3_r.scale;
    ctx_nxt[S_DOT].role0  = (s3_r.role == 2'd0);
    if (s3_r.role[1])
      ctx_nxt[S_DOT].st = snsf_pkg::ST_NO_SURFACE;
    else if (s3_r.nsq == '0 || s3_r.cnt == '0 || s3_r.rsq >= cutoff_sq_r)
      ctx_nxt[S_DOT].st = snsf_pkg::ST_SKIPPED;
    else
      ctx_nxt[S_DOT].st = snsf_pkg::ST_APPLIED;
    isq_nxt[S_DOT].rem  = '0;
    isq_nxt[S_DOT].root = '0;
    isq_nxt[S_DOT].rad  = {s3_r.nsq, 32'd0};

    for (int i = S_DOT + 1; i <= S_G1; i++) ctx_nxt[i] = ctx_r[i-1];

    // square root of |n|^2 << 32, two radicand bits per step
    for (int i = S_DOT + 1; i <= ISQ_LAST; i++) begin
      is = isq_r[i-1];
      for (int k = 0; k < ISQ_STEPS; k++) is = isq_step(is);
      isq_nxt[i] = is;
    end

    // normal distance (|d.n| << 16) / sqrt(|n|^2 << 32), one quotient bit per step
    for (int i = DIV_FIRST; i <= DIV_LAST; i++) begin
      if (i == DIV_FIRST) begin
        ds.rem = {16'd0, ctx_r[ISQ_LAST].dot[63:48]};
        ds.dq  = {ctx_r[ISQ_LAST].dot[47:0], 16'd0};
        ds.nr  = isq_r[ISQ_LAST].root;
      end else begin
        ds = div_r[i-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) ds = div_step(ds);
      div_nxt[i] = ds;
    end

    // S_T1: squares for the tangential test
    nd2_nxt = (|div_r[DIV_LAST].dq[63:32]) ? '1
            : div_r[DIV_LAST].dq[31:0] * div_r[DIV_LAST].dq[31:0];
    tc2_nxt = tang_cutoff_r * tang_cutoff_r;

    // S_T2
    tang2 = (ctx_r[S_T1].rsq > nd2_r) ? ctx_r[S_T1].rsq - nd2_r : '0;
    if (ctx_r[S_T1].st == snsf_pkg::ST_APPLIED && tang2 > tc2_r)
      ctx_nxt[S_T2].st = snsf_pkg::ST_SKIPPED;

    // S_F1: delta = rest_length - projection
    proj = ctx_r[S_T2].dot[63:14];
    ctx_nxt[S_F1].dneg = proj > 50'(rest_length_r);
    ctx_nxt[S_F1].dmag = (proj > 50'(rest_length_r)) ? proj - 50'(rest_length_r)
                                                     : 50'(rest_length_r) - proj;

    // S_F2: scale
    tp    = ctx_r[S_F1].dmag * ctx_r[S_F1].scale;
    t_nxt = tp[66:16];

    // S_F3: spring constant, split in two partial products
    pl_nxt = t_r[31:0] * spring_k_r;
    ph_nxt = t_r[50:32] * spring_k_r;

    // S_F4
    full84  = 84'(pl_r) + 84'({ph_r, 32'd0});
    pre_nxt = (|full84[83:80]) ? '1 : full84[79:16];

    // S_F5: doubled prefactor and energy partial products
    pre2_nxt  = pre_r[63] ? '1 : {pre_r[62:0], 1'b0};
    ep_nxt.ll = pre_r[31:0]  * ctx_r[S_F4].dmag[31:0];
    ep_nxt.lh = pre_r[31:0]  * ctx_r[S_F4].dmag[49:32];
    ep_nxt.hl = pre_r[63:32] * ctx_r[S_F4].dmag[31:0];
    ep_nxt.hh = pre_r[63:32] * ctx_r[S_F4].dmag[49:32];

    // S_F6: energy, count divide seed
    sum114 = 114'(ep_r.ll) + 114'({ep_r.lh, 32'd0}) + 114'({ep_r.hl, 32'd0})
           + {ep_r.hh, 64'd0};
    ctx_nxt[S_F6].energy = (|sum114[113:64]) ? '1 : sum114[63:16];
    cdv_nxt[S_F6].rem = '0;
    cdv_nxt[S_F6].dq  = pre2_r;

    // divide by contributor count
    for (int i = S_F6 + 1; i <= CDV_LAST; i++) begin
      cs = cdv_r[i-1];
      for (int k = 0; k < CDV_STEPS; k++) cs = cdv_step(cs, ctx_r[i-1].cnt);
      cdv_nxt[i] = cs;
    end

    // S_G1: force partial products
    for (int c = 0; c < 3; c++) begin
      fp_nxt.fl[c] = cdv_r[CDV_LAST].dq[31:0]  * ctx_r[CDV_LAST].nm[c];
      fp_nxt.fh[c] = cdv_r[CDV_LAST].dq[63:32] * ctx_r[CDV_LAST].nm[c];
    end

    // S_G2: rescale, sign and clamp
    for (int c = 0; c < 3; c++) begin
      p80   = 80'(fp_r.fl[c]) + {fp_r.fh[c], 32'd0};
      big   = |p80[79:45];
      mag32 = {1'b0, p80[44:14]};
      neg   = ctx_r[S_G1].dneg ^ ctx_r[S_G1].nn[c] ^ ctx_r[S_G1].role0;
      if (ctx_r[S_G1].st != snsf_pkg::ST_APPLIED) res_nxt.f[c] = '0;
      else if (neg) res_nxt.f[c] = big ? 32'h8000_0000 : (~mag32 + 1'b1);
      else          res_nxt.f[c] = big ? 32'h7FFF_FFFF : mag32;
    end
    res_nxt.energy = (ctx_r[S_G1].st == snsf_pkg::ST_APPLIED) ? ctx_r[S_G1].energy : '0;
    res_nxt.st     = ctx_r[S_G1].st;
  end

  always_comb begin
    if (skid_v_r) skid_v_nxt = !out_ready;
    else          skid_v_nxt = v_r[S_G2] && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
      if (en) v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      for (int i = S_DOT; i <= S_G1; i++) ctx_r[i] <= ctx_nxt[i];
      for (int i = S_DOT; i <= ISQ_LAST; i++) isq_r[i] <= isq_nxt[i];
      for (int i = DIV_FIRST; i <= DIV_LAST; i++) div_r[i] <= div_nxt[i];
      for (int i = S_F6; i <= CDV_LAST; i++) cdv_r[i] <= cdv_nxt[i];
      nd2_r  <= nd2_nxt;
      tc2_r  <= tc2_nxt;
      t_r    <= t_nxt;
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      pre_r  <= pre_nxt;
      pre2_r <= pre2_nxt;
      ep_r   <= ep_nxt;
      fp_r   <= fp_nxt;
      res_r  <= res_nxt;
      skid_r <= res_r;
    end
  end

  assign out_sel         = skid_v_r ? skid_r : res_r;
  assign out_valid       = skid_v_r || v_r[S_G2];
  assign out_force_x     = out_sel.f[0];
  assign out_force_y     = out_sel.f[1];
  assign out_force_z     = out_sel.f[2];
  assign out_pair_energy = out_sel.energy;
  assign out_status      = out_sel.st;

`ifndef SYNTHESIS
  a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_v_r && v_r[S_G2] && !out_ready) |=> skid_v_r)
    else $error("stalled word not held in skid register");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ready) |=> ($stable(v_r) && skid_v_r))
    else $error("pipeline moved while skid register full");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != snsf_pkg::ST_APPLIED) |->
      (out_force_x == 0 && out_force_y == 0 && out_force_z == 0 && out_pair_energy == 0))
    else $error("skipped word carries nonzero force or energy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("unused status code on output");
`endif

endmodule
`default_nettype wire

// ===== sim/snsf_checker.sv =====
// Checker for the surface normal spring force block: watches the channels, predicts, compares.
`timescale 1ns / 1ps
module snsf_checker
  import snsf_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int MAX_CONTRIBUTORS = MAX_CONTRIB_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_del_x,
  input  logic signed [COORD_WIDTH-1:0] in_del_y,
  input  logic signed [COORD_WIDTH-1:0] in_del_z,
  input  logic signed [15:0]            in_normal_x,
  input  logic signed [15:0]            in_normal_y,
  input  logic signed [15:0]            in_normal_z,
  input  logic [6:0]                    in_contributors,
  input  logic [16:0]                   in_special_scale,
  input  logic [1:0]                    in_surface_role,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [31:0]            out_force_x,
  input  logic signed [31:0]            out_force_y,
  input  logic signed [31:0]            out_force_z,
  input  logic [47:0]                   out_pair_energy,
  input  logic [1:0]                    out_status,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            applied_count,
  output int                            skipped_count,
  output int                            no_surface_count
);

  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic [47:0] energy;
    logic [1:0]  status;
  } force_word_t;

  logic [31:0] k_reg, rest_reg, tang_reg;
  logic [63:0] cut_reg;
  force_word_t expected_words[$];

  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAX64 : s[63:0];
  endfunction

  // exact (a*b) >> s, saturated to 64 bits
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    return (p[127:64] != 0) ? MAX64 : p[63:0];
  endfunction

  function automatic logic [63:0] sqrt64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_force(logic neg, logic [63:0] mag);
    if (mag == 0) return 32'd0;
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic force_word_t predict_spring_force(
      logic [COORD_WIDTH-1:0] d0, logic [COORD_WIDTH-1:0] d1, logic [COORD_WIDTH-1:0] d2,
      logic [15:0] n0, logic [15:0] n1, logic [15:0] n2,
      logic [6:0] cnt_in, logic [16:0] scale, logic [1:0] role);
    force_word_t w;
    logic [COORD_WIDTH-1:0] dv[3];
    logic [15:0] nv[3];
    logic [63:0] dm[3], nm[3];
    logic dn[3], nn[3];
    logic [63:0] rsq, nsq, pos, negsum, dot, p, nr, q, r, nd, nd2, tang2, tlim;
    logic [63:0] proj, dmag, t, pre, fpair, energy, cnt;
    logic [127:0] nd_sq;
    logic dneg;
    w = '0;
    if (role > 2'd1) begin
      w.status = ST_NO_SURFACE;
      return w;
    end
    dv[0] = d0; dv[1] = d1; dv[2] = d2;
    nv[0] = n0; nv[1] = n1; nv[2] = n2;
    rsq = 0; nsq = 0; pos = 0; negsum = 0;
    for (int c = 0; c < 3; c++) begin
      dn[c] = dv[c][COORD_WIDTH-1];
      nn[c] = nv[c][15];
      // sign-extend to 64 bits first so the most negative value keeps its magnitude
      dm[c] = 64'($signed(dv[c]));
      if (dn[c]) dm[c] = 64'd0 - dm[c];
      nm[c] = 64'($signed(nv[c]));
      if (nn[c]) nm[c] = 64'd0 - nm[c];
      rsq = sat_add64(rsq, mul_shift(dm[c], dm[c], 0));
      nsq = nsq + nm[c] * nm[c];
      p = dm[c] * nm[c];
      if (dn[c] != nn[c]) negsum = negsum + p;
      else pos = pos + p;
    end
    w.status = ST_SKIPPED;
    if (nsq == 0 || cnt_in == 0) return w;
    cnt = (cnt_in > MAX_CONTRIBUTORS) ? 64'(MAX_CONTRIBUTORS) : 64'(cnt_in);
    dot = (pos >= negsum) ? pos - negsum : negsum - pos;
    nr = sqrt64(nsq << 32);
    q = dot / nr;
    r = dot % nr;
    nd = (q >= (64'd1 << 48)) ? MAX64 : (q << 16) + (r << 16) / nr;
    nd_sq = {64'd0, nd} * {64'd0, nd};
    nd2 = (nd_sq[127:64] != 0) ? MAX64 : nd_sq[63:0];
    tang2 = (rsq > nd2) ? rsq - nd2 : 64'd0;
    tlim = 64'(tang_reg) * 64'(tang_reg);
    if (rsq >= cut_reg || tang2 > tlim) return w;
    proj = dot >> 14;
    dneg = proj > 64'(rest_reg);
    dmag = dneg ? proj - 64'(rest_reg) : 64'(rest_reg) - proj;
    t = mul_shift(dmag, 64'(scale), 16);
    pre = mul_shift(t, 64'(k_reg), 16);
    fpair = ((pre > MAX64 / 2) ? MAX64 : pre * 2) / cnt;
    energy = mul_shift(pre, dmag, 16);
    w.fx = clamp_force((dneg != nn[0]) != (role == 2'd0), mul_shift(fpair, nm[0], 14));
    w.fy = clamp_force((dneg != nn[1]) != (role == 2'd0), mul_shift(fpair, nm[1], 14));
    w.fz = clamp_force((dneg != nn[2]) != (role == 2'd0), mul_shift(fpair, nm[2], 14));
    w.energy = (energy > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : energy[47:0];
    w.status = ST_APPLIED;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    force_word_t want;
    if (!rst_n) begin
      k_reg <= SPRING_K_RST;
      rest_reg <= REST_LENGTH_RST;
      cut_reg <= CUTOFF_SQ_RST;
      tang_reg <= TANG_CUTOFF_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SPRING_K:    k_reg <= cfg_data[31:0];
          REG_REST_LENGTH: rest_reg <= cfg_data[31:0];
          REG_CUTOFF_SQ:   cut_reg <= cfg_data;
          REG_TANG_CUTOFF: tang_reg <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_words.push_back(predict_spring_force(in_del_x, in_del_y, in_del_z,
            in_normal_x, in_normal_y, in_normal_z, in_contributors, in_special_scale,
            in_surface_role));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_status), 64'd0);
        end else begin
          want = expected_words.pop_front();
          if (out_force_x != want.fx) report_mismatch("force_x", 64'(out_force_x), 64'(want.fx));
          if (out_force_y != want.fy) report_mismatch("force_y", 64'(out_force_y), 64'(want.fy));
          if (out_force_z != want.fz) report_mismatch("force_z", 64'(out_force_z), 64'(want.fz));
          if (out_pair_energy != want.energy)
            report_mismatch("pair_energy", 64'(out_pair_energy), 64'(want.energy));
          if (out_status != want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          case (status_t'(want.status))
            ST_APPLIED:    applied_count++;
            ST_SKIPPED:    skipped_count++;
            default:       no_surface_count++;
          endcase
        end
      end
    end
    pending = expected_words.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    applied_count = 0;
    skipped_count = 0;
    no_surface_count = 0;
  end

endmodule

// ===== sim/surface_normal_spring_force_test.sv =====
// Top of the surface normal spring force testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module surface_normal_spring_force_test;
  import snsf_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 850;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_del_x = '0, in_del_y = '0, in_del_z = '0;
  logic signed [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [6:0] in_contributors = '0;
  logic [16:0] in_special_scale = '0;
  logic [1:0] in_surface_role = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_force_x, out_force_y, out_force_z;
  logic [47:0] out_pair_energy;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, pending, applied_count, skipped_count, no_surface_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int words_sent = 0;

  always #5 clk = ~clk;

  surface_normal_spring_force u_top (.*);

  snsf_checker u_checker (.*);

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
      logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
      logic [6:0] cnt, logic [16:0] scale, logic [1:0] role);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_del_x <= dx; in_del_y <= dy; in_del_z <= dz;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_contributors <= cnt;
    in_special_scale <= scale;
    in_surface_role <= role;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(logic [31:0] k, logic [31:0] rest, logic [63:0] cut,
      logic [31:0] tang);
    write_reg(REG_SPRING_K, k);
    write_reg(REG_REST_LENGTH, rest);
    write_reg(REG_CUTOFF_SQ, cut);
    write_reg(REG_TANG_CUTOFF, tang);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return 32'($signed($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32767)) - 16384);
      2: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic send_random_word();
    logic [1:0] role;
    logic [6:0] cnt;
    logic [16:0] scale;
    logic [15:0] nx, ny, nz;
    // mostly pairs that reach the force path, some noise
    if ($urandom_range(9) == 0) begin
      role = 2'($urandom);
      cnt = 7'($urandom);
      scale = 17'($urandom);
    end else begin
      role = 2'($urandom_range(1));
      cnt = 7'($urandom_range(1, 64));
      scale = $urandom_range(3) == 0 ? 17'd65536 : 17'($urandom_range(0, 65536));
    end
    nx = rand_normal(); ny = rand_normal(); nz = rand_normal();
    if ($urandom_range(49) == 0) begin
      nx = 0; ny = 0; nz = 0;
    end
    send_word(rand_coord(), rand_coord(), rand_coord(), nx, ny, nz, cnt, scale, role);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset configuration, then with open cutoffs
    for (int pass = 0; pass < 2; pass++) begin
      send_word(0, 0, 0, 16'sd16384, 0, 0, 7'd1, 17'd65536, 2'd0);
      send_word(0, 0, 0, 0, 0, 16'sd16384, 7'd1, 17'd65536, 2'd1);
      send_word(32'h0000_8000, 0, 0, 16'sd16384, 0, 0, 7'd2, 17'd65536, 2'd0);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -16'sd32768, -16'sd32768,
                -16'sd32768, 7'd64, 17'd65536, 2'd0);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd32767, 16'sd32767,
                16'sd32767, 7'd127, 17'h1FFFF, 2'd1);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'sd32767, -16'sd32768, 0,
                7'd65, 17'd65536, 2'd0);
      send_word(32'h0000_4000, 0, 0, 16'sd16384, 0, 0, 7'd0, 17'd65536, 2'd0);
      send_word(32'h0000_4000, 0, 0, 0, 0, 0, 7'd3, 17'd65536, 2'd1);
      send_word(32'h0000_4000, 0, 0, 16'sd16384, 0, 0, 7'd3, 17'd65536, 2'd2);
      send_word(32'h0000_4000, 0, 0, 16'sd16384, 0, 0, 7'd3, 17'd65536, 2'd3);
      send_word(32'h0000_4000, 32'h0000_2000, 0, 16'sd16384, 0, 0, 7'd1, 17'd0, 2'd0);
      send_word(32'h0003_0000, 0, 0, -16'sd16384, 0, 0, 7'd1, 17'd32768, 2'd1);
      send_word(0, 32'h0000_C000, 0, 0, 16'sd16384, 0, 7'd1, 17'd65536, 2'd0);
      send_word(32'h0000_1000, 32'h0001_0000, 0, 16'sd16384, 0, 0, 7'd1, 17'd65536, 2'd0);
      send_word(32'hFFFF_C000, 32'hFFFF_F000, 32'h0000_1000, 16'sd11585, -16'sd11585,
                16'sd1, 7'd5, 17'd65535, 2'd1);
      drain_and_idle();
      if (pass == 0)
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_config(32'h0002_0000, 32'h0001_8000, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        1: load_config(32'd0, 32'd0, 64'd0, 32'd0);
        2: load_config($urandom, $urandom_range(0, 32'h0004_0000),
                       {$urandom, $urandom}, $urandom);
        3: load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0000_0100_0000_0000, 32'h0010_0000);
        default: load_config(32'h0001_0000, 32'h0000_8000, 64'hFFFF_FFFF_FFFF_FFFF,
                             32'h0100_0000);
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        case ((i * 4) / (RANDOM_ITEMS / 5))
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
          default: begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
        if (phase == 0 && i == 10) hold_request <= 1'b1;
        send_random_word();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain_and_idle();
    end

    $display("Sent %0d words over seven register settings and four idle patterns.", words_sent);
    $display("Results: %0d applied, %0d skipped, %0d with no surface atom.",
             applied_count, skipped_count, no_surface_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
